/* src/two_line_text_panel_controller_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the two-line text panel controller
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TWO_LINE_TEXT_PANEL_CONTROLLER_ASSERT_SVH
`define TWO_LINE_TEXT_PANEL_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define TLP_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TLP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tlp_pkg.sv */
// ----------------------------------------------------------------------------
// tlp_pkg
// Types, codes and geometry shared by the text panel controller modules.
// ----------------------------------------------------------------------------
package tlp_pkg;

  localparam int ROW_CHARS  = 20;
  localparam int SCREEN_LEN = 2 * ROW_CHARS;
  localparam int ADDR_W     = $clog2(SCREEN_LEN);
  localparam int CUR_W      = $clog2(SCREEN_LEN + 1);

  localparam logic [7:0] CMD_HOME   = 8'h02;
  localparam logic [7:0] CMD_LINE2  = 8'hC0;
  localparam logic [7:0] BYTE_ESC   = 8'd27;
  localparam logic [7:0] BYTE_FF    = 8'd12;
  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_Y     = 8'h59;
  localparam logic [7:0] CHAR_X     = 8'h58;

  localparam logic [1:0] LED_OFF    = 2'd0;
  localparam logic [1:0] LED_RED    = 2'd1;
  localparam logic [1:0] LED_GREEN  = 2'd2;
  localparam logic [1:0] LED_YELLOW = 2'd3;

  typedef enum logic [2:0] {
    KIND_CMD   = 3'd0,
    KIND_DATA  = 3'd1,
    KIND_LED   = 3'd2,
    KIND_KEY   = 3'd3,
    KIND_NOKEY = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POLL_KEY,
    ST_RF_HOME,
    ST_RF_DATA,
    ST_RF_LINE2
  } tlp_state_e;

  typedef enum logic [2:0] {
    OSEL_LED,
    OSEL_KEY,
    OSEL_HOME,
    OSEL_LINE2,
    OSEL_DATA
  } out_sel_e;

  typedef struct packed {
    logic       command;
    logic [7:0] char_byte;
    logic       end_of_write;
    logic [1:0] button_bits;
  } tlp_in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [1:0] led_drive;
    logic       last;
  } tlp_out_t;

  // controller -> datapath
  typedef struct packed {
    logic     latch_in;
    logic     exec_byte;
    logic     poll_done;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     out_load;
    out_sel_e out_sel;
    logic     out_last;
  } tlp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_poll;
    logic esc_pending;
    logic eow;
    logic out_free;
    logic cnt_row_end;
    logic cnt_end;
  } tlp_sts_t;

endpackage

/* src/tlp_ctrl.sv */
// ----------------------------------------------------------------------------
// tlp_ctrl
// Sequencer: item intake, byte execution, poll results and screen refresh.
// ----------------------------------------------------------------------------
module tlp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tlp_pkg::tlp_sts_t sts_i,
  output tlp_pkg::tlp_ctl_t ctl_o
);
  import tlp_pkg::*;

  tlp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    ctl_o         = '0;
    ctl_o.out_sel = OSEL_LED;
    in_ready_o    = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch_in = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.is_poll) begin
          if (sts_i.out_free) begin
            ctl_o.out_load = 1'b1;
            ctl_o.out_sel  = OSEL_LED;
            state_d        = ST_POLL_KEY;
          end
        end else if (!sts_i.esc_pending || sts_i.out_free) begin
          ctl_o.exec_byte = 1'b1;
          if (sts_i.esc_pending) begin
            ctl_o.out_load = 1'b1;
            ctl_o.out_sel  = OSEL_LED;
            ctl_o.out_last = !sts_i.eow;
          end
          state_d = sts_i.eow ? ST_RF_HOME : ST_IDLE;
        end
      end
      ST_POLL_KEY: begin
        if (sts_i.out_free) begin
          ctl_o.out_load  = 1'b1;
          ctl_o.out_sel   = OSEL_KEY;
          ctl_o.out_last  = 1'b1;
          ctl_o.poll_done = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_RF_HOME: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_sel  = OSEL_HOME;
          ctl_o.cnt_clr  = 1'b1;
          state_d        = ST_RF_DATA;
        end
      end
      ST_RF_DATA: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_sel  = OSEL_DATA;
          ctl_o.out_last = sts_i.cnt_end;
          if (sts_i.cnt_end) begin
            state_d = ST_IDLE;
          end else if (sts_i.cnt_row_end) begin
            state_d = ST_RF_LINE2;
          end else begin
            ctl_o.cnt_inc = 1'b1;
          end
        end
      end
      ST_RF_LINE2: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_sel  = OSEL_LINE2;
          ctl_o.cnt_inc  = 1'b1;
          state_d        = ST_RF_DATA;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/tlp_dp.sv */
// ----------------------------------------------------------------------------
// tlp_dp
// Screen store, cursor, LED and button state, refresh counter, result register.
// ----------------------------------------------------------------------------
`include "two_line_text_panel_controller_assert.svh"

module tlp_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tlp_pkg::tlp_in_t  in_i,
  input  tlp_pkg::tlp_ctl_t ctl_i,
  output tlp_pkg::tlp_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tlp_pkg::tlp_out_t out_o
);
  import tlp_pkg::*;

  // Rows are rotated rather than copied: top_q names the physical row
  // that holds logical row 0.
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] idx,
                                                  input logic top);
    logic [ADDR_W-1:0] res;
    if (!top) begin
      res = idx;
    end else if (idx < ADDR_W'(ROW_CHARS)) begin
      res = idx + ADDR_W'(ROW_CHARS);
    end else begin
      res = idx - ADDR_W'(ROW_CHARS);
    end
    return res;
  endfunction

  tlp_in_t               item_q;
  logic [CUR_W-1:0]      cursor_q, cursor_d;
  logic                  top_q, top_d;
  logic                  esc_q, esc_d;
  logic [1:0]            led_q, led_d;
  logic [1:0]            btn_q, btn_d;
  logic [SCREEN_LEN-1:0] valid_q, valid_d;
  logic [ADDR_W-1:0]     cnt_q, cnt_d;
  logic [7:0]            mem_q [SCREEN_LEN];
  logic [7:0]            rd_q;
  logic                  rd_vld_q;
  logic                  out_valid_q;
  tlp_out_t              out_q, out_d;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_idx;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  do_scroll;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  key_up;
  logic                  key_dn;
  logic                  out_free;

  // item capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_in) begin
      item_q <= in_i;
    end
  end

  // byte execution
  always_comb begin
    cursor_d  = cursor_q;
    top_d     = top_q;
    esc_d     = esc_q;
    led_d     = led_q;
    valid_d   = valid_q;
    wr_en     = 1'b0;
    do_scroll = 1'b0;
    wr_idx    = cursor_q[ADDR_W-1:0];
    wr_addr   = '0;
    if (ctl_i.exec_byte) begin
      if (esc_q) begin
        esc_d = 1'b0;
        case (item_q.char_byte)
          CHAR_R:  led_d = LED_RED;
          CHAR_G:  led_d = LED_GREEN;
          CHAR_Y:  led_d = LED_YELLOW;
          CHAR_X:  led_d = LED_OFF;
          default: led_d = led_q;
        endcase
      end else if (item_q.char_byte == BYTE_ESC) begin
        esc_d = 1'b1;
      end else if (item_q.char_byte == BYTE_FF) begin
        valid_d  = '0;
        cursor_d = '0;
      end else if (item_q.char_byte == BYTE_LF) begin
        if (cursor_q < CUR_W'(ROW_CHARS)) begin
          cursor_d = CUR_W'(ROW_CHARS);
        end else if (cursor_q < CUR_W'(SCREEN_LEN)) begin
          cursor_d = CUR_W'(SCREEN_LEN);
        end else begin
          do_scroll = 1'b1;
        end
      end else begin
        do_scroll = (cursor_q == CUR_W'(SCREEN_LEN));
        wr_en     = 1'b1;
      end
      if (item_q.end_of_write) begin
        esc_d = 1'b0;
      end
    end
    if (do_scroll) begin
      // old top row becomes the blank bottom row
      top_d    = ~top_q;
      cursor_d = CUR_W'(ROW_CHARS);
      for (int i = 0; i < SCREEN_LEN; i++) begin
        if ((i >= ROW_CHARS) == top_q) begin
          valid_d[i] = 1'b0;
        end
      end
    end
    if (wr_en) begin
      wr_idx   = do_scroll ? ADDR_W'(ROW_CHARS) : cursor_q[ADDR_W-1:0];
      cursor_d = CUR_W'(wr_idx) + CUR_W'(1);
      wr_addr  = phys_addr(wr_idx, top_d);
      valid_d[wr_addr] = 1'b1;
    end
  end

  assign btn_d = ctl_i.poll_done ? item_q.button_bits : btn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      top_q    <= 1'b0;
      esc_q    <= 1'b0;
      led_q    <= LED_OFF;
      btn_q    <= 2'b11;
      valid_q  <= '0;
      cnt_q    <= '0;
    end else begin
      cursor_q <= cursor_d;
      top_q    <= top_d;
      esc_q    <= esc_d;
      led_q    <= led_d;
      btn_q    <= btn_d;
      valid_q  <= valid_d;
      cnt_q    <= cnt_d;
    end
  end

  // refresh counter and screen read
  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.cnt_clr) begin
      cnt_d = '0;
    end else if (ctl_i.cnt_inc) begin
      cnt_d = cnt_q + ADDR_W'(1);
    end
  end

  assign rd_en   = ctl_i.cnt_clr | ctl_i.cnt_inc;
  assign rd_addr = phys_addr(cnt_d, top_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= item_q.char_byte;
    end
    if (rd_en) begin
      rd_q     <= mem_q[rd_addr];
      rd_vld_q <= valid_q[rd_addr];
    end
  end

  // result register
  assign key_up   = !btn_q[0] && item_q.button_bits[0];
  assign key_dn   = !btn_q[1] && item_q.button_bits[1];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_d.led_drive = led_d;
    out_d.last      = ctl_i.out_last;
    case (ctl_i.out_sel)
      OSEL_LED: begin
        out_d.kind  = KIND_LED;
        out_d.value = {6'b0, led_d};
      end
      OSEL_KEY: begin
        if (key_up) begin
          out_d.kind  = KIND_KEY;
          out_d.value = CHAR_SPACE;
        end else if (key_dn) begin
          out_d.kind  = KIND_KEY;
          out_d.value = CHAR_CR;
        end else begin
          out_d.kind  = KIND_NOKEY;
          out_d.value = '0;
        end
      end
      OSEL_HOME: begin
        out_d.kind  = KIND_CMD;
        out_d.value = CMD_HOME;
      end
      OSEL_LINE2: begin
        out_d.kind  = KIND_CMD;
        out_d.value = CMD_LINE2;
      end
      OSEL_DATA: begin
        out_d.kind  = KIND_DATA;
        out_d.value = rd_vld_q ? rd_q : CHAR_SPACE;
      end
      default: begin
        out_d.kind  = KIND_NOKEY;
        out_d.value = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign sts_o.is_poll     = item_q.command;
  assign sts_o.esc_pending = esc_q;
  assign sts_o.eow         = item_q.end_of_write;
  assign sts_o.out_free    = out_free;
  assign sts_o.cnt_row_end = (cnt_q == ADDR_W'(ROW_CHARS - 1));
  assign sts_o.cnt_end     = (cnt_q == ADDR_W'(SCREEN_LEN - 1));

  `TLP_ASSERT_IMPLY(a_load_when_free, clk_i, rst_ni, ctl_i.out_load, out_free, "result overwritten")
  `TLP_ASSERT_IMPLY(a_cursor_range, clk_i, rst_ni, 1'b1, cursor_q <= CUR_W'(SCREEN_LEN), "cursor out of range")
  `TLP_ASSERT_NEXT(a_scroll_lf, clk_i, rst_ni, do_scroll && !wr_en, cursor_q == CUR_W'(ROW_CHARS), "scroll cursor")
  `TLP_ASSERT_IMPLY(a_no_write_in_refresh, clk_i, rst_ni, rd_en, !wr_en, "screen write during refresh")

endmodule

/* src/two_line_text_panel_controller.sv */
// ----------------------------------------------------------------------------
// two_line_text_panel_controller
// Front panel controller: 2-row character screen, two-color LED, two keys.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o / in_i): one item is either a
//   display byte (command = 0) or a button poll (command = 1).
// Output channel (out_valid_o / out_ready_i / out_o): display commands,
//   display characters, LED updates and key reports; last marks the final
//   result of an item.
// Timing: an item is taken in the idle state and then executed. An LED
//   result is loaded when its item executes. A poll gives two results,
//   the LED code and then the key report. A last byte starts a refresh of
//   2*ROW_CHARS+2 results (42 by default), one per cycle while the receiver
//   takes them, read one character a cycle from the screen store through
//   its registered read port.
// Stall: a single output register holds the pending result; the sequencer
//   waits while it is full and not taken. The next item is accepted as soon
//   as the last result sits in that register.
// Reset: screen reads as all spaces (per-entry valid bits cleared at once,
//   no clearing pass), cursor 0, LED off, both buttons seen released.
// ----------------------------------------------------------------------------
module two_line_text_panel_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tlp_pkg::tlp_in_t in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tlp_pkg::tlp_out_t out_o
);
  import tlp_pkg::*;

  // command and status between sequencer and datapath
  tlp_ctl_t ctl;
  tlp_sts_t sts;

  // sequencer: intake, execute, poll and refresh steps
  tlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // datapath: screen store, cursor, LED/button state, result register
  tlp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

/* sim/tb_two_line_text_panel_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_line_text_panel_controller
// Self-checking bench for the front panel controller. Display bytes and
// button polls go in over a valid/ready channel. A behavioral panel model
// (screen, cursor, escape flag, LED code, last button lines) predicts every
// result. A monitor compares each result taken from the output channel
// against the oldest prediction. Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module tb_two_line_text_panel_controller;
  import tlp_pkg::*;

  // Item opcodes on the command bit.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_POLL  = 1'b1;

  // Slowest legal run: ~380 items, each up to 43 results with the longest
  // stall per result plus the longest input gap. Take that about seven
  // times over.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // Settle time after the last awaited result.
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned ITEM_TARGET = 360;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     panel_in_valid = 1'b0;
  tlp_in_t  panel_in = '0;
  logic     panel_out_ready = 1'b0;
  logic     in_ready;
  logic     out_valid;
  tlp_out_t panel_out;

  // Idle-cycle insertion, switched per phase so that some stretches run
  // back to back.
  logic idle_inputs = 1'b1;
  logic idle_outputs = 1'b1;

  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Panel model state.
  logic [7:0] screen_chars [SCREEN_LEN];
  int         cursor_pos;
  logic       escape_armed;
  logic [1:0] led_state;
  logic [1:0] buttons_seen;

  // Results predicted but not yet seen on the output channel.
  tlp_out_t awaited_results [$];

  two_line_text_panel_controller u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (panel_in_valid),
    .in_ready_o  (in_ready),
    .in_i        (panel_in),
    .out_valid_o (out_valid),
    .out_ready_i (panel_out_ready),
    .out_o       (panel_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Panel model
  // --------------------------------------------------------------------------
  function automatic void reset_panel_model();
    for (int i = 0; i < SCREEN_LEN; i++) screen_chars[i] = CHAR_SPACE;
    cursor_pos   = 0;
    escape_armed = 1'b0;
    led_state    = LED_OFF;
    buttons_seen = 2'b11;
  endfunction

  // Every result carries the LED code in force once it is produced.
  function automatic void await_result(kind_e k, logic [7:0] v);
    tlp_out_t r;
    r.kind      = k;
    r.value     = v;
    r.led_drive = led_state;
    r.last      = 1'b0;
    awaited_results.push_back(r);
  endfunction

  // Row 1 moves up, row 1 blanks, cursor lands at the start of row 1.
  function automatic void scroll_screen();
    for (int i = 0; i < ROW_CHARS; i++) begin
      screen_chars[i]             = screen_chars[i + ROW_CHARS];
      screen_chars[i + ROW_CHARS] = CHAR_SPACE;
    end
    cursor_pos = ROW_CHARS;
  endfunction

  function automatic void predict_panel_results(tlp_in_t it);
    int unsigned queued_before;
    queued_before = awaited_results.size();
    if (it.command == CMD_POLL) begin
      await_result(KIND_LED, {6'd0, led_state});
      // Release = line going 0 -> 1; upper key wins over lower.
      if (!buttons_seen[0] && it.button_bits[0]) begin
        await_result(KIND_KEY, CHAR_SPACE);
      end else if (!buttons_seen[1] && it.button_bits[1]) begin
        await_result(KIND_KEY, CHAR_CR);
      end else begin
        await_result(KIND_NOKEY, 8'h00);
      end
      buttons_seen = it.button_bits;
    end else begin
      if (escape_armed) begin
        case (it.char_byte)
          CHAR_R:  led_state = LED_RED;
          CHAR_G:  led_state = LED_GREEN;
          CHAR_Y:  led_state = LED_YELLOW;
          CHAR_X:  led_state = LED_OFF;
          default: ;
        endcase
        escape_armed = 1'b0;
        await_result(KIND_LED, {6'd0, led_state});
      end else if (it.char_byte == BYTE_ESC) begin
        escape_armed = 1'b1;
      end else if (it.char_byte == BYTE_FF) begin
        for (int i = 0; i < SCREEN_LEN; i++) screen_chars[i] = CHAR_SPACE;
        cursor_pos = 0;
      end else if (it.char_byte == BYTE_LF) begin
        if (cursor_pos < ROW_CHARS) cursor_pos = ROW_CHARS;
        else if (cursor_pos < SCREEN_LEN) cursor_pos = SCREEN_LEN;
        else scroll_screen();
      end else begin
        if (cursor_pos >= SCREEN_LEN) scroll_screen();
        screen_chars[cursor_pos] = it.char_byte;
        cursor_pos++;
      end
      // Last byte: full refresh, and any escape just armed is dropped.
      if (it.end_of_write) begin
        escape_armed = 1'b0;
        await_result(KIND_CMD, CMD_HOME);
        for (int i = 0; i < ROW_CHARS; i++) await_result(KIND_DATA, screen_chars[i]);
        await_result(KIND_CMD, CMD_LINE2);
        for (int i = ROW_CHARS; i < SCREEN_LEN; i++) await_result(KIND_DATA, screen_chars[i]);
      end
    end
    if (awaited_results.size() > queued_before)
      awaited_results[awaited_results.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Item builders and the input driver
  // --------------------------------------------------------------------------
  function automatic tlp_in_t byte_item(logic [7:0] b, logic eow);
    tlp_in_t it;
    it.command      = CMD_WRITE;
    it.char_byte    = b;
    it.end_of_write = eow;
    it.button_bits  = 2'($urandom_range(0, 3));  // don't-care on a write
    return it;
  endfunction

  function automatic tlp_in_t poll_item(logic [1:0] lines);
    tlp_in_t it;
    it.command      = CMD_POLL;
    it.char_byte    = 8'($urandom_range(0, 255));  // don't-care on a poll
    it.end_of_write = 1'($urandom_range(0, 1));
    it.button_bits  = lines;
    return it;
  endfunction

  // Drives at the falling edge, holds until taken at a rising edge, then
  // books the predicted results. Valid only drops for an idle gap.
  task automatic send_item(tlp_in_t it);
    int unsigned gap;
    gap = idle_inputs ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      panel_in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    panel_in_valid <= 1'b1;
    panel_in       <= it;
    do @(posedge clk); while (!in_ready);
    predict_panel_results(it);
    items_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random backpressure per result, and the result checker
  // --------------------------------------------------------------------------
  initial begin : out_ready_driver
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = idle_outputs ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        panel_out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      panel_out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic void check_panel_result(tlp_out_t got);
    tlp_out_t want;
    if (awaited_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("ERROR: unexpected result kind=%0d value=%02h led=%0d last=%0b",
                 got.kind, got.value, got.led_drive, got.last);
      return;
    end
    want = awaited_results.pop_front();
    if (got.kind !== want.kind || got.value !== want.value ||
        got.led_drive !== want.led_drive || got.last !== want.last) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("ERROR: result mismatch exp kind=%0d value=%02h led=%0d last=%0b,",
                 want.kind, want.value, want.led_drive, want.last,
                 " got kind=%0d value=%02h led=%0d last=%0b",
                 got.kind, got.value, got.led_drive, got.last);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && panel_out_ready) check_panel_result(panel_out);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("two_line_text_panel_controller test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Refresh after reset shows a blank screen plus the new byte; byte extremes.
  task automatic test_refresh_and_byte_extremes();
    send_item(byte_item("A", 1'b1));
    send_item(byte_item(8'h00, 1'b0));
    send_item(byte_item(8'hFF, 1'b1));
  endtask

  // Escape followed by each LED letter, an unknown letter, an escape as the
  // last byte (dropped by the refresh) and an escape held across a poll.
  task automatic test_led_escapes();
    send_item(byte_item(BYTE_ESC, 1'b0));
    send_item(byte_item(CHAR_R, 1'b0));
    send_item(byte_item(BYTE_ESC, 1'b0));
    send_item(byte_item(CHAR_G, 1'b0));
    send_item(byte_item(BYTE_ESC, 1'b0));
    send_item(byte_item(CHAR_Y, 1'b0));
    send_item(byte_item(BYTE_ESC, 1'b0));
    send_item(byte_item(CHAR_X, 1'b0));
    send_item(byte_item(BYTE_ESC, 1'b0));
    send_item(byte_item("q", 1'b0));
    send_item(byte_item(BYTE_ESC, 1'b1));
    send_item(byte_item(CHAR_R, 1'b0));      // plain character now
    send_item(byte_item(BYTE_ESC, 1'b0));
    send_item(poll_item(2'b00));             // escape must survive the poll
    send_item(byte_item(CHAR_Y, 1'b1));      // LED result, then a refresh
  endtask

  // Key detection: lower release, upper release and no key.
  task automatic test_button_polls();
    send_item(poll_item(2'b11));
    send_item(poll_item(2'b00));
    send_item(poll_item(2'b10));
    send_item(poll_item(2'b01));
    send_item(poll_item(2'b01));
  endtask

  // Clear, line feeds to the bottom, scroll by a character and by a LF.
  task automatic test_cursor_moves();
    send_item(byte_item(BYTE_FF, 1'b0));
    send_item(byte_item(BYTE_LF, 1'b0));
    send_item(byte_item(BYTE_LF, 1'b0));
    send_item(byte_item("Z", 1'b1));
    send_item(byte_item(BYTE_LF, 1'b0));
    send_item(byte_item(BYTE_LF, 1'b1));
  endtask

  // --------------------------------------------------------------------------
  // Random traffic: mostly whole writes (bytes ending in a last byte) with
  // random content, mixed with polls, broken writes and raw noise items.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_text_byte(logic after_escape);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (after_escape) begin
      case ($urandom_range(0, 4))
        0: return CHAR_R;
        1: return CHAR_G;
        2: return CHAR_Y;
        3: return CHAR_X;
        default: return 8'($urandom_range(0, 255));
      endcase
    end
    if (roll < 62) return 8'($urandom_range(32, 126));
    if (roll < 74) return 8'($urandom_range(0, 255));
    if (roll < 84) return BYTE_LF;
    if (roll < 90) return BYTE_FF;
    return BYTE_ESC;
  endfunction

  task automatic send_random_write();
    int unsigned len;
    logic        broken;
    logic        after_escape;
    logic [7:0]  b;
    // Long writes push the cursor past the bottom row.
    len = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 45) : $urandom_range(1, 12);
    broken = ($urandom_range(0, 9) == 0);
    after_escape = 1'b0;
    for (int k = 0; k < len; k++) begin
      b = pick_text_byte(after_escape);
      after_escape = !after_escape && (b == BYTE_ESC);
      send_item(byte_item(b, (k == len - 1) && !broken));
      if ($urandom_range(0, 19) == 0) send_item(poll_item(2'($urandom_range(0, 3))));
    end
  endtask

  task automatic test_random_traffic(int unsigned item_goal);
    int unsigned roll;
    tlp_in_t     noise;
    while (items_sent < item_goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        send_item(poll_item(2'($urandom_range(0, 3))));
      end else if (roll < 23) begin
        noise = tlp_in_t'(12'($urandom_range(0, 4095)));
        send_item(noise);
      end else begin
        send_random_write();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_panel_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_refresh_and_byte_extremes();
    test_led_escapes();
    test_button_polls();
    test_cursor_moves();

    test_random_traffic(items_sent + 130);
    // Back to back on both sides.
    idle_inputs  = 1'b0;
    idle_outputs = 1'b0;
    test_random_traffic(items_sent + 50);
    // Fast sender, slow receiver, then the reverse.
    idle_outputs = 1'b1;
    test_random_traffic(items_sent + 50);
    idle_inputs  = 1'b1;
    idle_outputs = 1'b0;
    test_random_traffic(items_sent + 50);
    idle_outputs = 1'b1;
    test_random_traffic(ITEM_TARGET);

    @(negedge clk);
    panel_in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("two_line_text_panel_controller test passed");
    end else begin
      $display("two_line_text_panel_controller test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/tlp_pkg.sv
src/tlp_ctrl.sv
src/tlp_dp.sv
src/two_line_text_panel_controller.sv
sim/tb_two_line_text_panel_controller.sv
